>>> src/acache_pkg.sv
// Shared types and constants for the address cache with aging.
// Holds the transaction structs, action and outcome codes and table sizing.
// Depends on nothing.
`default_nettype none

package acache_pkg;

  // Number of table entries, from 1 to 256.
  localparam int ENTRIES = 16;
  // Index width of one table entry.
  localparam int IDX_W = (ENTRIES > 1) ? $clog2(ENTRIES) : 1;

  localparam int IP_W   = 32;
  localparam int MAC_W  = 48;
  localparam int LIFE_W = 16;
  localparam int SLOT_W = 8;

  // Reset value of the time-to-live reload register.
  localparam logic [LIFE_W-1:0] TTL_RESET = 16'd30000;

  // Configuration port.
  localparam int PADDR_W = 3;
  localparam logic REG_TTL_RELOAD = 1'b0;  // word index taken from paddr[2]

  // Action codes. The fourth code does nothing and returns an all-zero result.
  localparam logic [1:0] ACT_TICK   = 2'd0;
  localparam logic [1:0] ACT_LEARN  = 2'd1;
  localparam logic [1:0] ACT_LOOKUP = 2'd2;

  // Learn outcome codes.
  localparam logic [2:0] OUT_NONE    = 3'd0;
  localparam logic [2:0] OUT_SAME    = 3'd1;
  localparam logic [2:0] OUT_CHANGED = 3'd2;
  localparam logic [2:0] OUT_FILLED  = 3'd3;
  localparam logic [2:0] OUT_EVICTED = 3'd4;

  typedef struct packed {
    logic [1:0]       action;
    logic [IP_W-1:0]  ip_addr;
    logic [MAC_W-1:0] mac_addr;
  } item_t;

  typedef struct packed {
    logic             hit;
    logic [MAC_W-1:0] mac_out;
    logic [2:0]       learn_outcome;
    logic [SLOT_W-1:0] slot;
  } result_t;

  // One word of the entry memory.
  typedef struct packed {
    logic [IP_W-1:0]   ip;
    logic [MAC_W-1:0]  mac;
    logic [LIFE_W-1:0] life;
  } entry_t;

endpackage

`default_nettype wire

>>> src/address_cache_with_aging.sv
// Top level of the address cache with aging: entry memory, scan sequencer
// and APB configuration register. Depends on acache_pkg.
`default_nettype none

// The cache keeps acache_pkg::ENTRIES pairs of IPv4 and MAC address, each with
// a valid mark and a time-to-live count. A transaction is accepted when start
// is high while busy is low. Tick, learn and lookup each sweep the entry memory
// once, one entry per cycle through its single read port, and busy stays high
// through the sweep and the drain and finish states that follow; done is
// registered from the finish state. The unused action code skips the sweep
// and goes straight from idle to the finish state.
// The result is on the result port for the single cycle in which done is high;
// the receiver cannot stall it, so it must take it then. A new transaction may
// be started in the same cycle that done is high. Valid marks live in flip-flops
// cleared by reset, so the block is ready right after reset with no clearing
// pass. The ttl_reload register sits at byte address 0 and may only be written
// while the block is idle.
module address_cache_with_aging (
  input  wire logic                              clk,
  input  wire logic                              rst,
  input  wire logic                              start,
  output logic                                   busy,
  input  wire acache_pkg::item_t                 item,
  output logic                                   done,
  output acache_pkg::result_t                    result,
  input  wire logic                              psel,
  input  wire logic                              penable,
  input  wire logic                              pwrite,
  input  wire logic [acache_pkg::PADDR_W-1:0]    paddr,
  input  wire logic [31:0]                       pwdata,
  output logic [31:0]                            prdata,
  output logic                                   pready
);

  typedef enum logic [3:0] {
    ST_IDLE   = 4'b0001,
    ST_SCAN   = 4'b0010,
    ST_DRAIN  = 4'b0100,
    ST_FINISH = 4'b1000
  } state_t;

  state_t state, state_next;

  // Entry memory: synchronous (registered) read, one write port.
  acache_pkg::entry_t mem [acache_pkg::ENTRIES];
  acache_pkg::entry_t rd_data;
  logic               wr_en;
  logic [acache_pkg::IDX_W-1:0] wr_addr;
  acache_pkg::entry_t wr_data;

  logic [acache_pkg::ENTRIES-1:0] valid;
  logic [acache_pkg::LIFE_W-1:0]  ttl_reload;

  acache_pkg::item_t cmd;  // the transaction being worked on

  // Scan pointer and the entry whose read data returns this cycle.
  logic [acache_pkg::IDX_W-1:0] idx;
  logic [acache_pkg::IDX_W-1:0] pend_idx;
  logic                         rd_pend;

  // Search results gathered during the sweep.
  logic                          found;
  logic [acache_pkg::IDX_W-1:0]  match_idx;
  logic [acache_pkg::MAC_W-1:0]  match_mac;
  logic                          free_found;
  logic [acache_pkg::IDX_W-1:0]  free_idx;

  logic                          pend_valid;
  logic                          ip_match;
  logic [acache_pkg::LIFE_W-1:0] life_dec;
  logic                          is_tick;
  logic                          is_learn;
  logic                          is_lookup;
  logic [acache_pkg::IDX_W-1:0]  target;
  logic [2:0]                    outcome;
  logic                          cfg_write;

  assign busy   = (state != ST_IDLE);
  assign pready = 1'b1;

  // ---------------------------------------------------------------------------
  // Configuration register
  // ---------------------------------------------------------------------------
  assign cfg_write = psel && penable && pwrite && pready &&
                     (paddr[2] == acache_pkg::REG_TTL_RELOAD);

  always_ff @(posedge clk) begin
    if (rst) begin
      ttl_reload <= acache_pkg::TTL_RESET;
    end else if (cfg_write) begin
      ttl_reload <= pwdata[acache_pkg::LIFE_W-1:0];
    end
  end

  always_comb begin
    prdata = '0;
    if (paddr[2] == acache_pkg::REG_TTL_RELOAD) begin
      prdata = {{(32-acache_pkg::LIFE_W){1'b0}}, ttl_reload};
    end
  end

  // ---------------------------------------------------------------------------
  // Decode of the held transaction and of the entry coming back from memory
  // ---------------------------------------------------------------------------
  assign is_tick    = (cmd.action == acache_pkg::ACT_TICK);
  assign is_learn   = (cmd.action == acache_pkg::ACT_LEARN);
  assign is_lookup  = (cmd.action == acache_pkg::ACT_LOOKUP);
  assign pend_valid = valid[pend_idx];
  assign ip_match   = pend_valid && (rd_data.ip == cmd.ip_addr);
  // An entry already at zero life stays at zero and is dropped.
  assign life_dec   = (rd_data.life != '0) ? (rd_data.life - 1'b1) : '0;

  // Slot chosen by a learn: the first match, else the first free slot, else
  // slot zero is overwritten.
  always_comb begin
    if (found) begin
      target  = match_idx;
      outcome = (match_mac == cmd.mac_addr) ? acache_pkg::OUT_SAME
                                            : acache_pkg::OUT_CHANGED;
    end else if (free_found) begin
      target  = free_idx;
      outcome = acache_pkg::OUT_FILLED;
    end else begin
      target  = '0;
      outcome = acache_pkg::OUT_EVICTED;
    end
  end

  // Memory write port. A tick writes back the entry whose read data has just
  // returned while the next entry is being read, so the two never share an address;
  // a learn writes only after the sweep has ended.
  always_comb begin
    wr_en   = 1'b0;
    wr_addr = pend_idx;
    wr_data = rd_data;
    if (rd_pend && is_tick && pend_valid) begin
      wr_en        = 1'b1;
      wr_data.life = life_dec;
    end else if ((state == ST_FINISH) && is_learn) begin
      wr_en   = 1'b1;
      wr_addr = target;
      wr_data = '{ip: cmd.ip_addr, mac: cmd.mac_addr, life: ttl_reload};
    end
  end

  always_ff @(posedge clk) begin
    rd_data <= mem[idx];
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
  end

  // ---------------------------------------------------------------------------
  // Sequencer
  // ---------------------------------------------------------------------------
  always_comb begin
    state_next = state;
    unique case (state)
      ST_IDLE: begin
        if (start) begin
          if (item.action == acache_pkg::ACT_TICK ||
              item.action == acache_pkg::ACT_LEARN ||
              item.action == acache_pkg::ACT_LOOKUP) begin
            state_next = ST_SCAN;
          end else begin
            state_next = ST_FINISH;
          end
        end
      end
      ST_SCAN: begin
        if (idx == acache_pkg::IDX_W'(acache_pkg::ENTRIES - 1)) begin
          state_next = ST_DRAIN;
        end
      end
      ST_DRAIN: begin
        state_next = ST_FINISH;
      end
      ST_FINISH: begin
        state_next = ST_IDLE;
      end
      default: begin
        state_next = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state   <= ST_IDLE;
      rd_pend <= 1'b0;
      done    <= 1'b0;
      valid   <= '0;
    end else begin
      state   <= state_next;
      rd_pend <= (state == ST_SCAN);
      done    <= (state == ST_FINISH);
      if (rd_pend && is_tick && pend_valid && (life_dec == '0)) begin
        valid[pend_idx] <= 1'b0;
      end
      if ((state == ST_FINISH) && is_learn) begin
        valid[target] <= 1'b1;
      end
    end
  end

  // Datapath registers; the sequencer qualifies every use, so no reset.
  always_ff @(posedge clk) begin
    pend_idx <= idx;
    if (state == ST_IDLE) begin
      cmd        <= item;
      idx        <= '0;
      found      <= 1'b0;
      free_found <= 1'b0;
    end else if (state == ST_SCAN) begin
      idx <= idx + 1'b1;
    end
    if (rd_pend && !is_tick) begin
      if (ip_match && !found) begin
        found     <= 1'b1;
        match_idx <= pend_idx;
        match_mac <= rd_data.mac;
      end
      if (!pend_valid && !free_found) begin
        free_found <= 1'b1;
        free_idx   <= pend_idx;
      end
    end
    if (state == ST_FINISH) begin
      if (is_learn) begin
        result <= '{hit: found, mac_out: '0, learn_outcome: outcome,
                    slot: acache_pkg::SLOT_W'(target)};
      end else if (is_lookup && found) begin
        result <= '{hit: 1'b1, mac_out: match_mac,
                    learn_outcome: acache_pkg::OUT_NONE,
                    slot: acache_pkg::SLOT_W'(match_idx)};
      end else begin
        result <= '0;
      end
    end
  end

  // ---------------------------------------------------------------------------
  // Assertions
  // ---------------------------------------------------------------------------
  a_done_after_finish: assert property (@(posedge clk) disable iff (rst)
    done |-> $past(state == ST_FINISH))
    else $error("result strobe without a finished sweep");

  a_start_goes_busy: assert property (@(posedge clk) disable iff (rst)
    (start && !busy) |=> busy)
    else $error("accepted transaction did not make the block busy");

  a_learn_slot_valid: assert property (@(posedge clk) disable iff (rst)
    (done && result.learn_outcome != acache_pkg::OUT_NONE)
      |-> valid[result.slot[acache_pkg::IDX_W-1:0]])
    else $error("learned slot is not marked valid");

  a_hit_outcome: assert property (@(posedge clk) disable iff (rst)
    (done && result.hit) |->
      (result.learn_outcome == acache_pkg::OUT_NONE ||
       result.learn_outcome == acache_pkg::OUT_SAME ||
       result.learn_outcome == acache_pkg::OUT_CHANGED))
    else $error("hit reported together with a fill outcome");

  a_mac_needs_hit: assert property (@(posedge clk) disable iff (rst)
    (done && result.mac_out != '0) |-> result.hit)
    else $error("MAC returned without a hit");

endmodule

`default_nettype wire

>>> tb/address_cache_with_aging_tb.sv
// Self-checking testbench for the address cache with aging.
// Drives transactions and APB writes, mirrors the table in a class and checks
// every result. Depends on acache_pkg and address_cache_with_aging.
`default_nettype none

module address_cache_with_aging_tb;
  import acache_pkg::*;

  // The fourth action code has no name in the package; it must do nothing.
  localparam logic [1:0] ACT_UNUSED = 2'd3;

  // Number of IP addresses that random traffic draws from. It is larger than
  // the table so that full-table learns and slot 0 evictions keep happening.
  localparam int POOL_SIZE = 24;

  // Ten random phases after the directed part, roughly 1450 items in total.
  localparam int PHASES = 10;
  localparam int ITEMS_PER_PHASE = 142;

  // Longest legal stretch without any accepted transaction: the longest sender
  // gap, one full sweep, a register write with read-back and the closing window,
  // taken several times over.
  localparam int WATCHDOG_LIMIT = 1000;

  // --------------------------------------------------------------------------
  // Mirror of the cache: its own copy of the table and of ttl_reload. Each
  // accepted transaction is applied to the copy, which yields the result the
  // block must return; those results wait in order until the block's results
  // arrive and are compared against them.
  // --------------------------------------------------------------------------
  class cache_mirror;
    bit                valid   [ENTRIES];
    logic [IP_W-1:0]   ip_of   [ENTRIES];
    logic [MAC_W-1:0]  mac_of  [ENTRIES];
    logic [LIFE_W-1:0] life    [ENTRIES];
    logic [LIFE_W-1:0] reload;
    result_t           awaited_results[$];
    int mismatches;
    int items_seen;
    int hits;
    int evictions;
    int expirations;

    function new();
      for (int i = 0; i < ENTRIES; i++) begin
        valid[i]  = 1'b0;
        ip_of[i]  = '0;
        mac_of[i] = '0;
        life[i]   = '0;
      end
      reload = TTL_RESET;
    endfunction

    function void set_reload(logic [LIFE_W-1:0] value);
      reload = value;
    endfunction

    // First valid entry holding the address, or -1.
    function int find_ip(logic [IP_W-1:0] addr);
      for (int i = 0; i < ENTRIES; i++) begin
        if (valid[i] && ip_of[i] == addr) return i;
      end
      return -1;
    endfunction

    function result_t apply_item(item_t it);
      result_t r;
      int      m;
      int      target;
      r = '0;
      unique case (it.action)
        ACT_TICK: begin
          // A valid entry already at zero life is not decremented, only dropped.
          for (int i = 0; i < ENTRIES; i++) begin
            if (valid[i]) begin
              if (life[i] != '0) life[i] = life[i] - 1'b1;
              if (life[i] == '0) begin
                valid[i] = 1'b0;
                expirations++;
              end
            end
          end
        end
        ACT_LEARN: begin
          m = find_ip(it.ip_addr);
          if (m >= 0) begin
            r.hit = 1'b1;
            r.learn_outcome = (mac_of[m] == it.mac_addr) ? OUT_SAME : OUT_CHANGED;
            target = m;
            hits++;
          end else begin
            target = -1;
            for (int i = 0; i < ENTRIES; i++) begin
              if (!valid[i] && target < 0) target = i;
            end
            if (target < 0) begin
              target = 0;
              r.learn_outcome = OUT_EVICTED;
              evictions++;
            end else begin
              r.learn_outcome = OUT_FILLED;
            end
            valid[target] = 1'b1;
            ip_of[target] = it.ip_addr;
          end
          mac_of[target] = it.mac_addr;
          life[target]   = reload;
          r.slot = SLOT_W'(target);
        end
        ACT_LOOKUP: begin
          m = find_ip(it.ip_addr);
          if (m >= 0) begin
            r.hit = 1'b1;
            r.mac_out = mac_of[m];
            r.slot = SLOT_W'(m);
            hits++;
          end
        end
        default: begin
        end
      endcase
      return r;
    endfunction

    function void note_item(item_t it);
      items_seen++;
      awaited_results.push_back(apply_item(it));
    endfunction

    task report(string what);
      $display("ERROR at %0t: %s", $time, what);
      mismatches++;
    endtask

    task check_result(result_t got);
      result_t want;
      if (awaited_results.size() == 0) begin
        report($sformatf("result %h arrived with nothing awaited", got));
        return;
      end
      want = awaited_results.pop_front();
      if (got.hit !== want.hit)
        report($sformatf("hit %b, expected %b", got.hit, want.hit));
      if (got.mac_out !== want.mac_out)
        report($sformatf("mac_out %h, expected %h", got.mac_out, want.mac_out));
      if (got.learn_outcome !== want.learn_outcome)
        report($sformatf("learn_outcome %0d, expected %0d",
                         got.learn_outcome, want.learn_outcome));
      if (got.slot !== want.slot)
        report($sformatf("slot %0d, expected %0d", got.slot, want.slot));
    endtask
  endclass

  // --------------------------------------------------------------------------
  // Clock, reset and the block's inputs, all known from time zero.
  // --------------------------------------------------------------------------
  logic                clk;
  logic                rst     = 1'b1;
  logic                start   = 1'b0;
  item_t               item    = '0;
  logic                psel    = 1'b0;
  logic                penable = 1'b0;
  logic                pwrite  = 1'b0;
  logic [PADDR_W-1:0]  paddr   = '0;
  logic [31:0]         pwdata  = '0;
  logic                busy;
  logic                done;
  result_t             result;
  logic [31:0]         prdata;
  logic                pready;

  cache_mirror mirror;

  logic [IP_W-1:0]  ip_pool  [POOL_SIZE];
  logic [MAC_W-1:0] mac_pool [POOL_SIZE];
  int settings_used;
  int idle_cycles;

  // Reload values for the random phases, extremes included, and the share of
  // items that the sender precedes with a gap. A zero share stands both for
  // the phases without idling and for those where only the receiver would
  // stall, since the receiver cannot hold results off.
  logic [LIFE_W-1:0] phase_ttl  [PHASES] = '{16'd5, 16'd1, 16'd65535, 16'd0, 16'd3,
                                             16'd12, 16'd2, 16'd30000, 16'd7, 16'd4};
  int                phase_idle [PHASES] = '{0, 70, 0, 22, 70, 0, 22, 70, 0, 22};

  address_cache_with_aging dut (
    .clk     (clk),
    .rst     (rst),
    .start   (start),
    .busy    (busy),
    .item    (item),
    .done    (done),
    .result  (result),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready)
  );

  initial begin
    clk = 1'b0;
    forever #1 clk = ~clk;
  end

  // --------------------------------------------------------------------------
  // Monitor. Everything is sampled at the rising edge, before the block's own
  // updates at that edge take effect: an input transaction is accepted where
  // start is high and busy low, a result wherever done is high.
  // --------------------------------------------------------------------------
  always @(posedge clk) begin
    if (!rst) begin
      if (start && !busy) mirror.note_item(item);
      if (done) mirror.check_result(result);
    end
  end

  // Watchdog: a run that stops making progress is a failure.
  always @(posedge clk) begin
    if (rst || (start && !busy) || done) begin
      idle_cycles <= 0;
    end else if (idle_cycles >= WATCHDOG_LIMIT) begin
      $display("Timeout: no transaction for %0d cycles", WATCHDOG_LIMIT);
      $display("CHECK FAILED");
      $finish;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
  end

  // --------------------------------------------------------------------------
  // Drivers. Each task assigns a signal at most once per time step, so start
  // stays high across back-to-back transactions without dropping.
  // --------------------------------------------------------------------------
  task automatic send_item(input item_t it);
    start <= 1'b1;
    item  <= it;
    do @(posedge clk); while (busy);
  endtask

  task automatic pause_cycles(input int n);
    if (n > 0) begin
      start <= 1'b0;
      repeat (n) @(posedge clk);
    end
  endtask

  // Hold off until every awaited result has come back and the block is idle.
  // The first edge lets the monitor record a transaction accepted just now.
  task automatic wait_drain();
    start <= 1'b0;
    @(posedge clk);
    while (mirror.awaited_results.size() != 0 || busy) @(posedge clk);
  endtask

  // Write ttl_reload through the APB port, then read it back. Upper data bits
  // carry noise that the register must ignore.
  task automatic set_ttl(input logic [LIFE_W-1:0] value);
    logic [31:0] readback;
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= PADDR_W'({REG_TTL_RELOAD, 2'b00});
    pwdata  <= {16'($urandom()), value};
    @(posedge clk);
    penable <= 1'b1;
    do @(posedge clk); while (!pready);
    psel    <= 1'b0;
    penable <= 1'b0;
    mirror.set_reload(value);
    @(posedge clk);
    psel    <= 1'b1;
    pwrite  <= 1'b0;
    @(posedge clk);
    penable <= 1'b1;
    do @(posedge clk); while (!pready);
    readback = prdata;
    psel    <= 1'b0;
    penable <= 1'b0;
    @(posedge clk);
    if (readback[LIFE_W-1:0] !== value)
      mirror.report($sformatf("ttl_reload reads %h, expected %h",
                              readback[LIFE_W-1:0], value));
    settings_used++;
  endtask

  function automatic item_t make_item(logic [1:0] action, logic [IP_W-1:0] ip,
                                      logic [MAC_W-1:0] mac);
    item_t it;
    it.action   = action;
    it.ip_addr  = ip;
    it.mac_addr = mac;
    return it;
  endfunction

  // Random traffic: mostly addresses from the pool so that learns refresh and
  // lookups hit, with a share of arbitrary addresses. Learns often repeat the
  // MAC last stored for a pool address to reach the same-MAC refresh.
  function automatic item_t random_item();
    item_t it;
    int    sel;
    int    k;
    sel = $urandom_range(99);
    k   = $urandom_range(POOL_SIZE - 1);
    if (sel < 22)      it.action = ACT_TICK;
    else if (sel < 60) it.action = ACT_LEARN;
    else if (sel < 95) it.action = ACT_LOOKUP;
    else               it.action = ACT_UNUSED;
    it.ip_addr  = ($urandom_range(99) < 85) ? ip_pool[k] : IP_W'($urandom());
    it.mac_addr = MAC_W'({$urandom(), $urandom()});
    if (it.action == ACT_LEARN && it.ip_addr == ip_pool[k]) begin
      if ($urandom_range(99) < 45) it.mac_addr = mac_pool[k];
      else mac_pool[k] = it.mac_addr;
    end
    return it;
  endfunction

  // --------------------------------------------------------------------------
  // Directed part: empty-table cases, the unused action with every bit set,
  // all-zero and all-one addresses, both kinds of refresh, filling the table
  // and the slot 0 eviction, then a zero reload aged by a tick.
  // --------------------------------------------------------------------------
  task automatic run_directed();
    send_item(make_item(ACT_LOOKUP, '0, '0));
    send_item(make_item(ACT_TICK, '1, '1));
    send_item(make_item(ACT_UNUSED, '1, '1));
    send_item(make_item(ACT_LEARN, '0, '0));
    send_item(make_item(ACT_LEARN, '1, '1));
    send_item(make_item(ACT_LEARN, '0, '0));
    send_item(make_item(ACT_LEARN, '0, '1));
    send_item(make_item(ACT_LOOKUP, '1, '0));
    // Slots 2 to 15 fill up, so the next new address has to evict slot 0.
    for (int i = 2; i < ENTRIES; i++)
      send_item(make_item(ACT_LEARN, 32'hC0A8_0100 + i, 48'h0200_0000_0000 + i));
    send_item(make_item(ACT_LEARN, 32'h0A0A_0A0A, 48'hA5A5_5A5A_A5A5));
    send_item(make_item(ACT_LOOKUP, '0, '0));
    // A zero reload gives a learned entry life 0; one tick drops it.
    wait_drain();
    set_ttl('0);
    send_item(make_item(ACT_LEARN, 32'h7F00_0001, 48'h0011_2233_4455));
    send_item(make_item(ACT_TICK, '0, '0));
    send_item(make_item(ACT_LOOKUP, 32'h7F00_0001, '0));
  endtask

  task automatic run_phase(input int gap_share);
    for (int n = 0; n < ITEMS_PER_PHASE; n++) begin
      if ($urandom_range(99) < gap_share) pause_cycles($urandom_range(1, 40));
      // Now and then the sender waits for every result before going on.
      if ($urandom_range(199) == 0) wait_drain();
      send_item(random_item());
    end
  endtask

  // --------------------------------------------------------------------------
  // Main sequence: reset once, the directed part starting under the reset
  // reload value, then one random phase per reload setting. Registers change
  // only once the block has drained; every transaction yields a result, so a
  // drained block is idle.
  // --------------------------------------------------------------------------
  initial begin
    mirror = new();
    settings_used = 1;
    idle_cycles = 0;
    for (int i = 0; i < POOL_SIZE; i++) begin
      ip_pool[i]  = IP_W'($urandom());
      mac_pool[i] = MAC_W'({$urandom(), $urandom()});
    end
    ip_pool[0] = '0;
    ip_pool[1] = '1;
    repeat (2) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    run_directed();
    for (int p = 0; p < PHASES; p++) begin
      wait_drain();
      set_ttl(phase_ttl[p]);
      run_phase(phase_idle[p]);
    end

    // Drain, then keep watching for a spell longer than one sweep so that a
    // stray result is caught.
    wait_drain();
    repeat (ENTRIES + 8) @(posedge clk);

    $display("Covered %0d transactions under %0d ttl_reload settings (0 and 65535 among them).",
             mirror.items_seen, settings_used);
    $display("Seen: %0d hits, %0d slot 0 evictions, %0d entries aged out.",
             mirror.hits, mirror.evictions, mirror.expirations);
    if (mirror.mismatches == 0) begin
      $display("CHECK OK");
    end else begin
      $display("CHECK FAILED");
    end
    $finish;
  end

endmodule

`default_nettype wire

>>> address_cache_with_aging.f
src/acache_pkg.sv
src/address_cache_with_aging.sv
tb/address_cache_with_aging_tb.sv
